// ----- hw/rtl/gta_pkg.sv -----
// ----------------------------------------------------------------------------
// gta_pkg
// shared types and constants of the greedy track association block
// ----------------------------------------------------------------------------
package gta_pkg;

  localparam int LABEL_W  = 16;
  localparam int SCORE_W  = 16;
  localparam int EXTENT_W = 23;
  localparam int TIME_W   = 63;
  localparam int IDENT_W  = 32;
  localparam int STATUS_W = 3;
  localparam int GATE_W   = 24;
  localparam int OUT_W    = 40;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TIME  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LABEL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDS   = 3'd4;

  localparam logic REG_GATE  = 1'b0;
  localparam logic REG_FIRST = 1'b1;

  typedef struct packed {
    logic               valid;
    logic               used;
    logic [LABEL_W-1:0] label;
    logic [IDENT_W-1:0] ident;
  } meta_t;

  typedef struct packed {
    logic shift;
    logic wr_en;
    logic clr_used;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/gta_cell.sv -----
// ----------------------------------------------------------------------------
// gta_cell
// one track entry of the circulating track ring
// ----------------------------------------------------------------------------
module gta_cell #(
  parameter int COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gta_pkg::cell_ctl_t        ctl,
  input  gta_pkg::meta_t            nb_meta,
  input  logic [3*COORD_BITS-1:0]   nb_ctr,
  input  gta_pkg::meta_t            wr_meta,
  input  logic [3*COORD_BITS-1:0]   wr_ctr,
  output gta_pkg::meta_t            meta,
  output logic [3*COORD_BITS-1:0]   ctr
);
  import gta_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta.valid <= 1'b0;
      meta.used  <= 1'b0;
    end else if (ctl.shift) begin
      meta <= nb_meta;
      ctr  <= nb_ctr;
    end else begin
      if (ctl.wr_en) begin
        meta.valid <= 1'b1;
        meta.label <= wr_meta.label;
        meta.ident <= wr_meta.ident;
        ctr        <= wr_ctr;
      end
      if (ctl.clr_used) begin
        meta.used <= 1'b0;
      end else if (ctl.wr_en) begin
        meta.used <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/greedy_track_association.sv -----
// ----------------------------------------------------------------------------
// greedy_track_association
// greedy nearest-neighbor association of observations to a track table
// ----------------------------------------------------------------------------
// Each observation passes through three states after acceptance: the track
// entries sit in a ring of cells that rotates once past one distance unit
// (three squarers, an adder and a compare) entry by entry in S_SCAN, then
// S_DRAIN drains the distance pipeline and S_DONE writes the chosen entry and
// loads the result register, waiting while an earlier result is still untaken.
// A new observation is taken only in S_IDLE, once the last one is through. The
// next observation is taken while a finished result still waits at the output.
module greedy_track_association #(
  parameter int MAX_TRACKS = 64,
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // observation stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // center_x, center_y, center_z, extent_x, extent_y, extent_z,
  // class_label, score, frame_time_ns, zero fill
  input  logic [((3*COORD_BITS+3*gta_pkg::EXTENT_W+gta_pkg::LABEL_W+gta_pkg::SCORE_W
                  +gta_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
  input  logic        s_tlast,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // track_ident, created, status, zero fill
  output logic [gta_pkg::OUT_W-1:0] m_tdata
);
  import gta_pkg::*;

  localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int C      = COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int BEST_W = 64;
  localparam int LBL_LO = 3*C + 3*EXTENT_W;
  localparam int TIM_LO = LBL_LO + LABEL_W + SCORE_W;

  state_t state, state_next;

  logic [GATE_W-1:0]   gate;
  logic [2*GATE_W-1:0] gate_sq;
  logic [IDENT_W-1:0]  first_id;
  logic [IDENT_W-1:0]  next_ident;
  logic [TIME_W-1:0]   last_time;
  logic                frame_seen;
  logic [CNT_W-1:0]    fill;

  logic [3*C-1:0]      obs_ctr;
  logic [LABEL_W-1:0]  obs_label;
  logic [TIME_W-1:0]   obs_time;
  logic                obs_fend;
  logic [STATUS_W-1:0] obs_status;
  logic [TIME_W-1:0]   in_time;
  logic [LABEL_W-1:0]  in_label;

  logic [IDX_W-1:0]    scan_idx;

  logic                sa_vld;
  logic                sa_elig;
  logic [IDX_W-1:0]    sa_idx;
  logic [IDENT_W-1:0]  sa_ident;
  logic [SQ_W-1:0]     sa_sq [3];

  logic [BEST_W-1:0]   best_d;
  logic                best_found;
  logic [IDX_W-1:0]    best_idx;
  logic [IDENT_W-1:0]  best_ident;
  logic [SUM_W-1:0]    dist_sum;

  meta_t               cell_meta [MAX_TRACKS];
  logic [3*C-1:0]      cell_ctr  [MAX_TRACKS];
  cell_ctl_t           cell_ctl  [MAX_TRACKS];
  meta_t               wr_meta;
  logic                wr_any;
  logic [IDX_W-1:0]    wr_idx;

  logic                res_status_ok;
  logic [STATUS_W-1:0] res_status;
  logic [IDENT_W-1:0]  res_ident;
  logic                res_created;
  logic                out_free;
  logic                done_fire;
  logic                s_fire;
  logic                cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_GATE) ? {{(32-GATE_W){1'b0}}, gate} : first_id;
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done_fire = (state == S_DONE) && out_free;
  assign in_time  = s_tdata[TIM_LO +: TIME_W];
  assign in_label = s_tdata[LBL_LO +: LABEL_W];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate     <= GATE_W'(1000);
      first_id <= IDENT_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GATE) begin
        gate <= pwdata[GATE_W-1:0];
      end else begin
        first_id <= pwdata;
      end
    end
  end

  assign gate_sq = {{GATE_W{1'b0}}, gate} * {{GATE_W{1'b0}}, gate};

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx == IDX_W'(MAX_TRACKS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // observation capture
  always_ff @(posedge clk) begin
    if (s_fire) begin
      obs_ctr   <= s_tdata[3*C-1:0];
      obs_label <= in_label;
      obs_time  <= in_time;
      obs_fend  <= s_tlast;
      if (frame_seen && (in_time < last_time)) begin
        obs_status <= ST_TIME;
      end else if (in_label == '0) begin
        obs_status <= ST_LABEL;
      end else begin
        obs_status <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (s_fire) begin
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  // distance of the ring head, first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else begin
      sa_vld <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    sa_elig  <= cell_meta[0].valid && !cell_meta[0].used && (cell_meta[0].label == obs_label);
    sa_idx   <= scan_idx;
    sa_ident <= cell_meta[0].ident;
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [C:0] diff;
    logic [C-1:0]      mag;
    always_comb begin
      diff = $signed({obs_ctr[a*C+C-1], obs_ctr[a*C +: C]})
           - $signed({cell_ctr[0][a*C+C-1], cell_ctr[0][a*C +: C]});
      mag  = diff[C] ? C'(-diff) : diff[C-1:0];
    end
    always_ff @(posedge clk) begin
      sa_sq[a] <= {{C{1'b0}}, mag} * {{C{1'b0}}, mag};
    end
  end

  // second stage: sum and best tracking, later entry wins on a tie
  assign dist_sum = SUM_W'(sa_sq[0]) + SUM_W'(sa_sq[1]) + SUM_W'(sa_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (s_fire) begin
      best_found <= 1'b0;
    end else if (sa_vld && sa_elig && (BEST_W'(dist_sum) <= best_d)) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      best_d <= BEST_W'(gate_sq);
    end else if (sa_vld && sa_elig && (BEST_W'(dist_sum) <= best_d)) begin
      best_d     <= BEST_W'(dist_sum);
      best_idx   <= sa_idx;
      best_ident <= sa_ident;
    end
  end

  // result decision
  always_comb begin
    res_status  = obs_status;
    res_ident   = '0;
    res_created = 1'b0;
    wr_any      = 1'b0;
    wr_idx      = best_idx;
    if (obs_status == ST_OK) begin
      if (best_found) begin
        res_ident = best_ident;
        wr_any    = 1'b1;
      end else if (next_ident == '1) begin
        res_status = ST_IDS;
      end else if (fill == CNT_W'(MAX_TRACKS)) begin
        res_status = ST_FULL;
      end else begin
        res_ident   = next_ident;
        res_created = 1'b1;
        wr_any      = 1'b1;
        wr_idx      = fill[IDX_W-1:0];
      end
    end
    res_status_ok = (res_status != ST_TIME);
  end

  assign wr_meta.valid = 1'b1;
  assign wr_meta.used  = 1'b1;
  assign wr_meta.label = obs_label;
  assign wr_meta.ident = res_ident;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ident <= IDENT_W'(1);
      fill       <= '0;
      last_time  <= '0;
      frame_seen <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_FIRST) && (fill == '0)) begin
        next_ident <= pwdata;
      end else if (done_fire && res_created) begin
        next_ident <= next_ident + IDENT_W'(1);
      end
      if (done_fire && res_created) begin
        fill <= fill + CNT_W'(1);
      end
      if (done_fire && obs_fend && res_status_ok) begin
        last_time  <= obs_time;
        frame_seen <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      m_tdata <= {{(OUT_W-IDENT_W-1-STATUS_W){1'b0}}, res_status, res_created, res_ident};
    end
  end

  // track ring
  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].shift    = (state == S_SCAN);
      cell_ctl[i].wr_en    = done_fire && wr_any && (wr_idx == IDX_W'(i));
      cell_ctl[i].clr_used = done_fire && obs_fend;
    end
    gta_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl[i]),
      .nb_meta (cell_meta[(i + 1) % MAX_TRACKS]),
      .nb_ctr  (cell_ctr[(i + 1) % MAX_TRACKS]),
      .wr_meta (wr_meta),
      .wr_ctr  (obs_ctr),
      .meta    (cell_meta[i]),
      .ctr     (cell_ctr[i])
    );
  end

endmodule

// ----- hw/rtl/gta_checker.sv -----
// ----------------------------------------------------------------------------
// gta_checker
// port-level checks of the greedy track association block
// ----------------------------------------------------------------------------
module gta_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import gta_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed under stall");

  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[35:33] == ST_OK)
    else $error("created flag on a rejected transaction");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[35:33] != ST_OK) |-> m_tdata[31:0] == '0)
    else $error("nonzero ident on a rejected transaction");

endmodule

bind greedy_track_association gta_checker u_gta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/greedy_track_association_tb.sv -----
// ----------------------------------------------------------------------------
// greedy_track_association_tb
// self-checking testbench for the greedy track association block
// ----------------------------------------------------------------------------
// Observations go in on the slave stream and results are checked against a
// behavioral track table that is kept in step with every accepted transaction.
// The run starts with a short directed table that covers the time, label and
// ident reject codes, the tie rule, coordinate extremes and the register
// writes. It then sends random frames of clustered observations mixed with
// noise, over several gate settings and idle patterns, and holds the result
// stream off once for a long stretch so that the block backs up.
module greedy_track_association_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gta_pkg::*;

  localparam int NTRK   = 64;
  localparam int CB     = 24;
  localparam int DATA_W = 240;

  typedef struct {
    logic signed [CB-1:0] cx, cy, cz;
    logic [EXTENT_W-1:0]  ex, ey, ez;
    logic [LABEL_W-1:0]   label;
    logic [SCORE_W-1:0]   score;
    logic [TIME_W-1:0]    t;
    logic                 fend;
  } obs_t;

  typedef struct {
    logic [IDENT_W-1:0]  ident;
    logic                created;
    logic [STATUS_W-1:0] status;
  } assoc_t;

  typedef struct {
    bit          is_cfg;
    logic        regsel;
    logic [31:0] val;
    obs_t        o;
    bit          typed;
    assoc_t      r;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic s_tvalid, s_tready, s_tlast;
  logic [DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;

  greedy_track_association u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // track table mirror
  bit                  trk_valid [NTRK];
  bit                  trk_used  [NTRK];
  logic [IDENT_W-1:0]  trk_ident [NTRK];
  logic [LABEL_W-1:0]  trk_label [NTRK];
  longint              trk_cx [NTRK], trk_cy [NTRK], trk_cz [NTRK];
  logic [IDENT_W-1:0]  next_id;
  logic [TIME_W-1:0]   last_time;
  bit                  frame_seen;
  logic [GATE_W-1:0]   gate_mm;

  assoc_t result_q[$];
  int     mismatches;
  int     send_idle_pct, recv_stall_pct;
  bit     hold_req;
  int     hold_left;
  logic [TIME_W-1:0] cur_time;
  longint clus_x[8], clus_y[8], clus_z[8];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic assoc_t associate_obs(obs_t o);
    assoc_t r;
    longint unsigned best_d, d;
    longint dx, dy, dz;
    int best, slot;
    r = '{ident: '0, created: 1'b0, status: ST_OK};
    if (frame_seen && o.t < last_time) begin
      r.status = ST_TIME;
    end else if (o.label == 0) begin
      r.status = ST_LABEL;
    end else begin
      best_d = longint'(gate_mm) * longint'(gate_mm);
      best = -1;
      for (int i = 0; i < NTRK; i++) begin
        if (trk_valid[i] && !trk_used[i] && trk_label[i] == o.label) begin
          dx = longint'(o.cx) - trk_cx[i];
          dy = longint'(o.cy) - trk_cy[i];
          dz = longint'(o.cz) - trk_cz[i];
          d = dx * dx + dy * dy + dz * dz;
          if (d <= best_d) begin
            best_d = d;
            best = i;
          end
        end
      end
      if (best < 0) begin
        slot = -1;
        for (int i = NTRK - 1; i >= 0; i--) if (!trk_valid[i]) slot = i;
        if (next_id == 32'hFFFF_FFFF) begin
          r.status = ST_IDS;
        end else if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          best = slot;
          trk_valid[slot] = 1;
          trk_ident[slot] = next_id;
          r.created = 1;
          next_id++;
        end
      end
      if (best >= 0) begin
        trk_used[best] = 1;
        trk_label[best] = o.label;
        trk_cx[best] = o.cx;
        trk_cy[best] = o.cy;
        trk_cz[best] = o.cz;
        r.ident = trk_ident[best];
      end
    end
    if (o.fend) begin
      foreach (trk_used[i]) trk_used[i] = 0;
      if (r.status != ST_TIME) begin
        last_time = o.t;
        frame_seen = 1;
      end
    end
    return r;
  endfunction

  function automatic obs_t mk_obs(int label, longint x, longint y, longint z,
                                  longint unsigned t, bit fend);
    obs_t o;
    o.cx = x; o.cy = y; o.cz = z;
    o.ex = $urandom; o.ey = $urandom; o.ez = $urandom;
    o.label = label; o.score = $urandom;
    o.t = t; o.fend = fend;
    return o;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic reg_write(logic regsel, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {regsel, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (regsel == REG_GATE) begin
      gate_mm = val[GATE_W-1:0];
    end else begin
      bit any_trk;
      any_trk = 0;
      foreach (trk_valid[i]) any_trk |= trk_valid[i];
      if (!any_trk) next_id = val;
    end
  endtask

  task automatic send_obs(obs_t o, bit typed, assoc_t r);
    assoc_t p;
    s_tvalid <= 1;
    s_tlast  <= o.fend;
    s_tdata  <= {4'b0, o.t, o.score, o.label, o.ez, o.ey, o.ex, o.cz, o.cy, o.cx};
    do @(posedge clk); while (!s_tready);
    p = associate_obs(o);
    if (typed) p = r;
    result_q = {result_q, p};
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic gen_obs(output obs_t o);
    int k;
    longint span;
    k = $urandom_range(7);
    span = $urandom_range(3) == 0 ? 20000 : 1500;
    if ($urandom_range(99) < 75) begin
      o = mk_obs(k % 4 + 1,
                 clus_x[k] + $urandom_range(2 * span) - span,
                 clus_y[k] + $urandom_range(2 * span) - span,
                 clus_z[k] + $urandom_range(2 * span) - span,
                 cur_time, $urandom_range(7) == 0);
      if (o.fend) cur_time += $urandom_range(5000);
    end else begin
      o = mk_obs($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(4),
                 $signed($urandom), $signed($urandom), $signed($urandom),
                 {$urandom, $urandom}, 1'b0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction %h", m_tdata);
        mismatches++;
      end else begin
        assoc_t e;
        e = result_q.pop_front();
        if (m_tdata[31:0] !== e.ident) begin
          $error("track_ident: expected %0d, got %0d", e.ident, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[32] !== e.created) begin
          $error("created: expected %0d, got %0d", e.created, m_tdata[32]);
          mismatches++;
        end
        if (m_tdata[35:33] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_tdata[35:33]);
          mismatches++;
        end
      end
    end
  end

  // result stream backpressure
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else begin
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    obs_t o;
    assoc_t none;
    longint unsigned pmax, nmin;
    pmax = 64'sd8388607;
    nmin = -64'sd8388608;
    none = '{ident: '0, created: 1'b0, status: ST_OK};
    mismatches = 0; hold_req = 0; hold_left = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tlast = 0; s_tdata = '0; m_tready = 0;
    foreach (trk_valid[i]) begin
      trk_valid[i] = 0;
      trk_used[i] = 0;
    end
    next_id = 1; last_time = '0; frame_seen = 0; gate_mm = 1000;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rw = '{is_cfg: 1, regsel: REG_FIRST, val: 32'hFFFF_FFFF, o: mk_obs(0, 0, 0, 0, 0, 0),
           typed: 0, r: none};
    rows = {rows, rw};
    rw.is_cfg = 0; rw.typed = 1;
    rw.o = mk_obs(5, 0, 0, 0, 100, 0); rw.r = '{0, 0, ST_IDS}; rows = {rows, rw};
    rw.o = mk_obs(0, 0, 0, 0, 100, 0); rw.r = '{0, 0, ST_LABEL}; rows = {rows, rw};
    rw.is_cfg = 1; rw.val = 1; rows = {rows, rw};
    rw.is_cfg = 0;
    rw.o = mk_obs(5, pmax, pmax, pmax, 100, 0); rw.r = '{1, 1, ST_OK}; rows = {rows, rw};
    rw.o = mk_obs(5, nmin, nmin, nmin, 100, 0); rw.r = '{2, 1, ST_OK}; rows = {rows, rw};
    rw.o = mk_obs(5, pmax, pmax, pmax, 100, 1); rw.r = '{3, 1, ST_OK}; rows = {rows, rw};
    rw.o = mk_obs(5, pmax - 500, pmax, pmax, 200, 0); rw.r = '{3, 0, ST_OK};
    rows = {rows, rw};
    rw.o = mk_obs(5, pmax, pmax, pmax, 200, 0); rw.r = '{1, 0, ST_OK}; rows = {rows, rw};
    rw.o = mk_obs(0, 0, 0, 0, 300, 1); rw.r = '{0, 0, ST_LABEL}; rows = {rows, rw};
    rw.o = mk_obs(5, 0, 0, 0, 299, 0); rw.r = '{0, 0, ST_TIME}; rows = {rows, rw};
    rw.o = mk_obs(7, 0, 0, 0, 299, 1); rw.r = '{0, 0, ST_TIME}; rows = {rows, rw};
    rw.o = mk_obs(7, 0, 0, 0, 300, 1); rw.r = '{4, 1, ST_OK};
    rw.o.ex = '1; rw.o.ey = '1; rw.o.ez = '1; rw.o.score = '1; rows = {rows, rw};
    rw.is_cfg = 1; rw.regsel = REG_GATE; rw.val = 1; rows = {rows, rw};
    rw.is_cfg = 0;
    rw.o = mk_obs(7, 1, 0, 0, 400, 1); rw.r = '{4, 0, ST_OK};
    rw.o.ex = '0; rw.o.ey = '0; rw.o.ez = '0; rw.o.score = '0; rows = {rows, rw};
    rw.o = mk_obs(16'hFFFF, 0, 0, 0, 400, 0); rw.r = '{5, 1, ST_OK}; rows = {rows, rw};
    rw.is_cfg = 1; rw.val = 24'hFF_FFFF; rows = {rows, rw};
    rw.is_cfg = 0; rw.typed = 0;
    rw.o = mk_obs(7, nmin, nmin, nmin, 500, 0); rows = {rows, rw};
    rw.o = mk_obs(16'hFFFF, pmax, nmin, pmax, 500, 1); rows = {rows, rw};
    rw.is_cfg = 1; rw.regsel = REG_FIRST; rw.val = 77; rows = {rows, rw};
    rw.is_cfg = 0;
    rw.o = mk_obs(9, 123, -456, 789, 600, 1); rows = {rows, rw};

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        reg_write(rows[i].regsel, rows[i].val);
      end else begin
        send_obs(rows[i].o, rows[i].typed, rows[i].r);
      end
    end

    foreach (clus_x[k]) begin
      clus_x[k] = $signed($urandom_range(16000000)) - 8000000;
      clus_y[k] = $signed($urandom_range(16000000)) - 8000000;
      clus_z[k] = $signed($urandom_range(16000000)) - 8000000;
    end
    cur_time = 1000;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: reg_write(REG_GATE, 1000);
        1: reg_write(REG_GATE, 1);
        2: reg_write(REG_GATE, 24'hFF_FFFF);
        3: reg_write(REG_FIRST, $urandom);
        default: reg_write(REG_GATE, $urandom_range(1, 50000));
      endcase
      send_idle_pct  = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 34 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 34 : 0;
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 230; n++) begin
        gen_obs(o);
        send_obs(o, 0, none);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_obs(mk_obs(1, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1), 0, none);
    send_obs(mk_obs(1, 0, 0, 0, 0, 0), 1, '{0, 0, ST_TIME});
    s_tvalid <= 0;

    for (int w = 0; w < 20000 && result_q.size() != 0; w++) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
